/* design/wsi_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsi_pkg
// Shared constants, command/status types and row helpers for the waypoint
// table slice interpolator.
// ----------------------------------------------------------------------------
package wsi_pkg;

	localparam int DATA_W        = 32;
	localparam int NCOL          = 5;
	localparam int ROW_W         = NCOL * DATA_W;
	localparam int STATE_COLUMNS = 5;
	localparam int TIME_COLUMN   = 0;
	localparam int MAX_ROWS_DEF  = 32;
	localparam int CFG_W         = 6;
	localparam int IDX_W         = 5;
	localparam int HOR_W         = 31;
	localparam int CNT_W         = 7;
	localparam int T_W           = 33;
	localparam int FRAC_W        = 30;
	localparam int ALPHA_W       = FRAC_W + 1;
	localparam int COL_W         = 3;
	localparam int DIV_CNT_W     = 5;
	localparam int PROD_W        = 64;

	// input item commands
	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_PLAN  = 1'b1;

	typedef logic [ROW_W-1:0] row_t;

	typedef struct packed {
		logic wr_row;
		logic capture;
		logic end_sel;
		logic scan_init;
		logic scan_step;
		logic div_step;
		logic mul_step;
		logic emit_s;
		logic inner_rd;
		logic inner_load;
		logic emit_e;
		logic emit_empty;
	} wsi_cmd_t;

	typedef struct packed {
		logic hit;
		logic miss;
		logic interp;
		logic div_last;
		logic mul_last;
		logic out_free;
		logic out_empty;
		logic inner_more;
	} wsi_stat_t;

	// Columns beyond the state width read as zero.
	function automatic row_t mask_row(input row_t r);
		row_t m;
		m = r;
		for (int c = 0; c < NCOL; c++) begin
			if (c >= STATE_COLUMNS) begin
				m[c*DATA_W +: DATA_W] = '0;
			end
		end
		return m;
	endfunction

	function automatic logic signed [DATA_W-1:0] time_of(input row_t r);
		return r[TIME_COLUMN*DATA_W +: DATA_W];
	endfunction

endpackage

/* design/wsi_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsi_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module wsi_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* design/wsi_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsi_ctrl
// Sequencer: row writes, segment scans for both query ends, divide,
// column interpolation and result emission.
// ----------------------------------------------------------------------------
module wsi_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              cmd,
	input  wsi_pkg::wsi_stat_t stat,
	output wsi_pkg::wsi_cmd_t  ctl
);
	import wsi_pkg::*;

	localparam logic [3:0] ST_IDLE      = 4'd0;
	localparam logic [3:0] ST_SCAN_INIT = 4'd1;
	localparam logic [3:0] ST_SCAN      = 4'd2;
	localparam logic [3:0] ST_DIV       = 4'd3;
	localparam logic [3:0] ST_MUL       = 4'd4;
	localparam logic [3:0] ST_EMIT_S    = 4'd5;
	localparam logic [3:0] ST_INNER     = 4'd6;
	localparam logic [3:0] ST_INNER_LD  = 4'd7;
	localparam logic [3:0] ST_EMIT_E    = 4'd8;
	localparam logic [3:0] ST_EMPTY     = 4'd9;

	logic [3:0] state_q, state_d;
	logic       end_sel_q, end_sel_d;

	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		state_d   = state_q;
		end_sel_d = end_sel_q;
		ctl       = '0;
		ctl.end_sel = end_sel_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (cmd == CMD_PLAN) begin
						ctl.capture = 1'b1;
						end_sel_d   = 1'b0;
						state_d     = ST_SCAN_INIT;
					end else if (cmd == CMD_WRITE) begin
						ctl.wr_row = 1'b1;
					end
				end
			end
			ST_SCAN_INIT: begin
				ctl.scan_init = 1'b1;
				state_d       = ST_SCAN;
			end
			ST_SCAN: begin
				ctl.scan_step = 1'b1;
				if (stat.hit) begin
					state_d = stat.interp ? ST_DIV : ST_MUL;
				end else if (stat.miss) begin
					state_d = ST_EMPTY;
				end
			end
			ST_DIV: begin
				ctl.div_step = 1'b1;
				if (stat.div_last) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				ctl.mul_step = 1'b1;
				if (stat.mul_last) begin
					if (!end_sel_q) begin
						end_sel_d = 1'b1;
						state_d   = ST_SCAN_INIT;
					end else begin
						state_d = ST_EMIT_S;
					end
				end
			end
			ST_EMIT_S: begin
				if (stat.out_free) begin
					ctl.emit_s = 1'b1;
					state_d    = ST_INNER;
				end
			end
			ST_INNER: begin
				// a stored row is read only into an empty output register
				if (!stat.inner_more) begin
					state_d = ST_EMIT_E;
				end else if (stat.out_empty) begin
					ctl.inner_rd = 1'b1;
					state_d      = ST_INNER_LD;
				end
			end
			ST_INNER_LD: begin
				ctl.inner_load = 1'b1;
				state_d        = ST_INNER;
			end
			ST_EMIT_E: begin
				if (stat.out_free) begin
					ctl.emit_e = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			ST_EMPTY: begin
				if (stat.out_free) begin
					ctl.emit_empty = 1'b1;
					state_d        = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			end_sel_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			end_sel_q <= end_sel_d;
		end
	end

endmodule

/* design/wsi_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsi_dp
// Datapath: row-count register, scan compare, restoring divider for alpha,
// three-stage column interpolation and the output register.
// ----------------------------------------------------------------------------
module wsi_dp #(
	parameter int MAX_ROWS = wsi_pkg::MAX_ROWS_DEF,
	localparam int AW = $clog2(MAX_ROWS)
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  wsi_pkg::wsi_cmd_t                  ctl,
	output wsi_pkg::wsi_stat_t                 stat,
	input  logic                               cfg_valid,
	input  logic [wsi_pkg::CFG_W-1:0]          cfg_data,
	input  logic [wsi_pkg::IDX_W-1:0]          row_index,
	input  logic signed [wsi_pkg::DATA_W-1:0]  value_0,
	input  logic signed [wsi_pkg::DATA_W-1:0]  value_1,
	input  logic signed [wsi_pkg::DATA_W-1:0]  value_2,
	input  logic signed [wsi_pkg::DATA_W-1:0]  value_3,
	input  logic signed [wsi_pkg::DATA_W-1:0]  value_4,
	input  logic signed [wsi_pkg::DATA_W-1:0]  plan_start,
	input  logic [wsi_pkg::HOR_W-1:0]          horizon,
	output logic                               ram_we,
	output logic [AW-1:0]                      ram_waddr,
	output wsi_pkg::row_t                      ram_wdata,
	output logic                               ram_re,
	output logic [AW-1:0]                      ram_raddr,
	input  wsi_pkg::row_t                      ram_rdata,
	input  logic                               out_stall,
	output logic                               out_valid,
	output logic signed [wsi_pkg::DATA_W-1:0]  out_0,
	output logic signed [wsi_pkg::DATA_W-1:0]  out_1,
	output logic signed [wsi_pkg::DATA_W-1:0]  out_2,
	output logic signed [wsi_pkg::DATA_W-1:0]  out_3,
	output logic signed [wsi_pkg::DATA_W-1:0]  out_4,
	output logic                               empty_res,
	output logic                               last
);
	import wsi_pkg::*;

	localparam logic [CFG_W-1:0] ROWS_MIN = CFG_W'(2);
	localparam logic [CFG_W-1:0] ROWS_MAX = CFG_W'(MAX_ROWS);
	localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(64'sd1 <<< (FRAC_W - 1));
	localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(1) << FRAC_W;

	// configuration
	logic [CFG_W-1:0] rows_q, rows_sat;

	always_comb begin
		if (cfg_data < ROWS_MIN) begin
			rows_sat = ROWS_MIN;
		end else if (cfg_data > ROWS_MAX) begin
			rows_sat = ROWS_MAX;
		end else begin
			rows_sat = cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= ROWS_MIN;
		end else if (cfg_valid) begin
			rows_q <= rows_sat;
		end
	end

	// row writes
	logic [CNT_W-1:0] wr_idx;
	assign wr_idx    = CNT_W'(row_index);
	assign ram_we    = ctl.wr_row && (wr_idx < CNT_W'(MAX_ROWS));
	assign ram_waddr = wr_idx[AW-1:0];
	assign ram_wdata = {value_4, value_3, value_2, value_1, value_0};

	// query times
	logic signed [T_W-1:0] t_start_q, t_end_q, t_cur;

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			t_start_q <= {plan_start[DATA_W-1], plan_start};
			t_end_q   <= {plan_start[DATA_W-1], plan_start} + {2'b00, horizon};
		end
	end

	assign t_cur = ctl.end_sel ? t_end_q : t_start_q;

	// segment scan
	logic [CNT_W-1:0]      scan_q, scan_nxt;
	row_t                  row_a_q, row_b_q;
	logic signed [T_W-1:0] ta_x, tb_x, num_c, den_c;
	logic                  hit_c, miss_c, at_lo_c, at_hi_c, interp_c;

	assign ta_x     = T_W'(time_of(row_a_q));
	assign tb_x     = T_W'(time_of(ram_rdata));
	assign scan_nxt = scan_q + CNT_W'(1);
	assign hit_c    = (scan_q != '0) && (ta_x <= t_cur) && (t_cur <= tb_x);
	assign miss_c   = (scan_q != '0) && !hit_c && (scan_nxt >= {1'b0, rows_q});
	assign at_lo_c  = (t_cur == ta_x) || (tb_x == ta_x);
	assign at_hi_c  = !at_lo_c && (t_cur == tb_x);
	assign interp_c = !at_lo_c && !at_hi_c;
	assign num_c    = t_cur - ta_x;
	assign den_c    = tb_x - ta_x;

	// divider and inner-row bounds
	logic [DATA_W-1:0]    rem_q, den_q, top_c;
	logic [FRAC_W-1:0]    hbits_q;
	logic [ALPHA_W-1:0]   alpha_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic [CNT_W-1:0]     s_first_q, e_end_q;
	logic [DATA_W+1:0]    trial;
	logic                 ge, top_ge;

	// dividend is num*2^30 + den/2; its top part can reach den, which gives
	// quotient bit 30 before the 30 shift steps
	assign top_c  = num_c[DATA_W-1:0] + DATA_W'(den_c[DATA_W-1]);
	assign top_ge = (top_c >= den_c[DATA_W-1:0]);
	assign trial  = {1'b0, rem_q, hbits_q[FRAC_W-1]} - {2'b00, den_q};
	assign ge     = !trial[DATA_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q    <= '0;
			div_cnt_q <= '0;
		end else if (ctl.scan_init) begin
			scan_q <= '0;
		end else if (ctl.scan_step) begin
			if (scan_q == '0) begin
				scan_q <= CNT_W'(1);
			end else if (!hit_c && !miss_c) begin
				scan_q <= scan_nxt;
			end
			div_cnt_q <= '0;
		end else if (ctl.div_step) begin
			div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.scan_step) begin
			if (scan_q == '0 || (!hit_c && !miss_c)) begin
				row_a_q <= ram_rdata;
			end else if (hit_c) begin
				row_b_q <= ram_rdata;
				alpha_q <= at_hi_c ? ALPHA_ONE : ALPHA_W'(interp_c && top_ge);
				rem_q   <= top_ge ? top_c - den_c[DATA_W-1:0] : top_c;
				hbits_q <= den_c[FRAC_W:1];
				den_q   <= den_c[DATA_W-1:0];
				if (!ctl.end_sel) begin
					s_first_q <= scan_q + CNT_W'(at_hi_c);
				end else begin
					e_end_q <= scan_q - CNT_W'(at_lo_c);
				end
			end
		end else if (ctl.div_step) begin
			rem_q   <= ge ? trial[DATA_W-1:0] : {rem_q[DATA_W-2:0], hbits_q[FRAC_W-1]};
			alpha_q <= {alpha_q[ALPHA_W-2:0], ge};
			hbits_q <= {hbits_q[FRAC_W-2:0], 1'b0};
		end
	end

	// column interpolation: difference, multiply, round and add
	logic [COL_W-1:0]           col_q, col_i, col_s1, col_s2;
	logic                       issue, v_s1, v_s2;
	logic signed [T_W-1:0]      diff_s1;
	logic signed [DATA_W-1:0]   a_c, b_c, a_s1, a_s2, res_c;
	logic signed [PROD_W-1:0]   prod_s2, rnd_c;
	row_t                       srow_q, erow_q;

	assign issue = ctl.mul_step && (col_q < COL_W'(NCOL));
	assign col_i = issue ? col_q : '0;
	assign a_c   = row_a_q[col_i*DATA_W +: DATA_W];
	assign b_c   = row_b_q[col_i*DATA_W +: DATA_W];
	assign rnd_c = (prod_s2 + RND_HALF) >>> FRAC_W;
	assign res_c = a_s2 + rnd_c[DATA_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
		end else begin
			col_q <= ctl.mul_step ? col_q + COL_W'(1) : '0;
			v_s1  <= issue;
			v_s2  <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		diff_s1 <= T_W'(b_c) - T_W'(a_c);
		a_s1    <= a_c;
		col_s1  <= col_i;
		prod_s2 <= PROD_W'($signed({1'b0, alpha_q}) * diff_s1);
		a_s2    <= a_s1;
		col_s2  <= col_s1;
		if (v_s2) begin
			if (ctl.end_sel) begin
				erow_q[col_s2*DATA_W +: DATA_W] <=
					(col_s2 < COL_W'(STATE_COLUMNS)) ? res_c : '0;
			end else begin
				srow_q[col_s2*DATA_W +: DATA_W] <=
					(col_s2 < COL_W'(STATE_COLUMNS)) ? res_c : '0;
			end
		end
	end

	// inner rows and RAM read port
	logic [CNT_W-1:0] idx_q;

	always_ff @(posedge clk) begin
		if (ctl.emit_s) begin
			idx_q <= s_first_q;
		end else if (ctl.inner_load) begin
			idx_q <= idx_q + CNT_W'(1);
		end
	end

	assign ram_re = ctl.scan_init || ctl.inner_rd ||
		(ctl.scan_step && !hit_c && !miss_c);

	always_comb begin
		if (ctl.scan_init) begin
			ram_raddr = '0;
		end else if (ctl.inner_rd) begin
			ram_raddr = idx_q[AW-1:0];
		end else begin
			ram_raddr = scan_nxt[AW-1:0];
		end
	end

	// output register
	logic out_valid_q, empty_q, last_q, load;
	row_t out_row_q;

	assign load = ctl.emit_s || ctl.inner_load || ctl.emit_e || ctl.emit_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (ctl.emit_s) begin
				out_row_q <= srow_q;
			end else if (ctl.emit_e) begin
				out_row_q <= erow_q;
			end else if (ctl.inner_load) begin
				out_row_q <= mask_row(ram_rdata);
			end else begin
				out_row_q <= '0;
			end
			empty_q <= ctl.emit_empty;
			last_q  <= ctl.emit_e || ctl.emit_empty;
		end
	end

	assign out_valid = out_valid_q;
	assign out_0     = out_row_q[0*DATA_W +: DATA_W];
	assign out_1     = out_row_q[1*DATA_W +: DATA_W];
	assign out_2     = out_row_q[2*DATA_W +: DATA_W];
	assign out_3     = out_row_q[3*DATA_W +: DATA_W];
	assign out_4     = out_row_q[4*DATA_W +: DATA_W];
	assign empty_res = empty_q;
	assign last      = last_q;

	assign stat.hit        = ctl.scan_step && hit_c;
	assign stat.miss       = ctl.scan_step && miss_c;
	assign stat.interp     = interp_c;
	assign stat.div_last   = (div_cnt_q == DIV_CNT_W'(FRAC_W - 1));
	assign stat.mul_last   = (col_q == COL_W'(NCOL + 1));
	assign stat.out_free   = !out_valid_q || !out_stall;
	assign stat.out_empty  = !out_valid_q;
	assign stat.inner_more = (idx_q < e_end_q);

endmodule

/* design/waypoint_table_slice_interpolator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// waypoint_table_slice_interpolator
// Waypoint table with piecewise-linear slicing between a start and end time.
// ----------------------------------------------------------------------------
// A write item stores one row. A plan item holds the input for its whole run:
// for each end the table is scanned one row per cycle, an end strictly inside
// a segment runs a restoring divider for alpha, and a pass interpolates the
// columns through one shared multiplier. Emission then outputs the start row,
// the stored inner rows and the end row. Each inner row is read from the table
// RAM only into an empty output register, and downstream stall holds emission.
// Unwritten rows have no defined content and the table needs no clearing after
// reset.
module waypoint_table_slice_interpolator #(
	parameter int MAX_ROWS = wsi_pkg::MAX_ROWS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [wsi_pkg::CFG_W-1:0]          cfg_data,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic                               cmd,
	input  logic [wsi_pkg::IDX_W-1:0]          row_index,
	input  logic signed [wsi_pkg::DATA_W-1:0]  value_0,
	input  logic signed [wsi_pkg::DATA_W-1:0]  value_1,
	input  logic signed [wsi_pkg::DATA_W-1:0]  value_2,
	input  logic signed [wsi_pkg::DATA_W-1:0]  value_3,
	input  logic signed [wsi_pkg::DATA_W-1:0]  value_4,
	input  logic signed [wsi_pkg::DATA_W-1:0]  plan_start,
	input  logic [wsi_pkg::HOR_W-1:0]          horizon,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [wsi_pkg::DATA_W-1:0]  out_0,
	output logic signed [wsi_pkg::DATA_W-1:0]  out_1,
	output logic signed [wsi_pkg::DATA_W-1:0]  out_2,
	output logic signed [wsi_pkg::DATA_W-1:0]  out_3,
	output logic signed [wsi_pkg::DATA_W-1:0]  out_4,
	output logic                               empty_res,
	output logic                               last
);
	import wsi_pkg::*;

	localparam int AW = $clog2(MAX_ROWS);

	wsi_cmd_t      ctl;
	wsi_stat_t     stat;
	logic          ram_we, ram_re;
	logic [AW-1:0] ram_waddr, ram_raddr;
	row_t          ram_wdata, ram_rdata;

	assign cfg_ready = 1'b1;

	wsi_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.cmd      (cmd),
		.stat     (stat),
		.ctl      (ctl)
	);

	wsi_dp #(
		.MAX_ROWS (MAX_ROWS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.stat       (stat),
		.cfg_valid  (cfg_valid),
		.cfg_data   (cfg_data),
		.row_index  (row_index),
		.value_0    (value_0),
		.value_1    (value_1),
		.value_2    (value_2),
		.value_3    (value_3),
		.value_4    (value_4),
		.plan_start (plan_start),
		.horizon    (horizon),
		.ram_we     (ram_we),
		.ram_waddr  (ram_waddr),
		.ram_wdata  (ram_wdata),
		.ram_re     (ram_re),
		.ram_raddr  (ram_raddr),
		.ram_rdata  (ram_rdata),
		.out_stall  (out_stall),
		.out_valid  (out_valid),
		.out_0      (out_0),
		.out_1      (out_1),
		.out_2      (out_2),
		.out_3      (out_3),
		.out_4      (out_4),
		.empty_res  (empty_res),
		.last       (last)
	);

	wsi_ram #(
		.WIDTH (ROW_W),
		.DEPTH (MAX_ROWS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

endmodule

/* design/wsi_chk.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsi_chk
// Port-level checks for the waypoint table slice interpolator.
// ----------------------------------------------------------------------------
module wsi_chk (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_stall,
	input logic                              cmd,
	input logic                              out_valid,
	input logic                              out_stall,
	input logic signed [wsi_pkg::DATA_W-1:0] out_0,
	input logic signed [wsi_pkg::DATA_W-1:0] out_1,
	input logic signed [wsi_pkg::DATA_W-1:0] out_2,
	input logic signed [wsi_pkg::DATA_W-1:0] out_3,
	input logic signed [wsi_pkg::DATA_W-1:0] out_4,
	input logic                              empty_res,
	input logic                              last
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_0) && $stable(last)
			&& $stable(empty_res))
		else $error("stalled result changed");

	// an empty result always closes its query
	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && empty_res |-> last)
		else $error("empty result without last");

	// an empty result carries zero columns
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && empty_res |-> (out_0 == 0) && (out_1 == 0) && (out_2 == 0)
			&& (out_3 == 0) && (out_4 == 0))
		else $error("empty result with nonzero columns");

	// a plan transfer keeps the input side busy afterwards
	a_plan_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && cmd |=> in_stall)
		else $error("input taken right after a plan");

endmodule

bind waypoint_table_slice_interpolator wsi_chk u_chk (.*);
